>>> rtl/core/i2cm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the I2C master bit engine.
// No dependencies; the front, queue, back and top level take names from here.
package i2cm_pkg;

  localparam int unsigned PHASE_TIMER_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH_DEF      = 4;
  localparam int unsigned PHASE_TICKS_BITS     = 16;
  localparam int unsigned CFG_INDEX_BITS       = 2;
  localparam int unsigned CFG_DATA_BITS        = 16;

  localparam logic [15:0] PHASE_TICKS_RST = 16'd5;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;
  localparam logic [6:0]  DEV_ADDR_RST    = 7'd0;
  localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_STOP      = 3'd2,
    CMD_WRITE     = 3'd3,
    CMD_ADDR_WR   = 3'd4,
    CMD_ADDR_RD   = 3'd5,
    CMD_READ_ACK  = 3'd6,
    CMD_READ_NACK = 3'd7
  } cmd_t;

  typedef enum logic [5:0] {
    PH_IDLE        = 6'd0,
    PH_ST_SDA_HI   = 6'd1,
    PH_ST_SCL_HI   = 6'd2,
    PH_ST_SDA_LO   = 6'd3,
    PH_ST_SCL_LO   = 6'd4,
    PH_SP_SCL_LO   = 6'd5,
    PH_SP_SDA_LO   = 6'd6,
    PH_SP_SCL_HI   = 6'd7,
    PH_SP_SDA_HI   = 6'd8,
    PH_WR_PREP     = 6'd9,
    PH_WR_BIT      = 6'd10,
    PH_WR_SCL_HI   = 6'd11,
    PH_WR_SCL_LO   = 6'd12,
    PH_WR_ACK_POLL = 6'd13,
    PH_WR_ACK_END  = 6'd14,
    PH_RD_RELEASE  = 6'd15,
    PH_RD_SCL_LO   = 6'd16,
    PH_RD_SCL_HI   = 6'd17,
    PH_RD_NEXT     = 6'd18,
    PH_RD_PREP     = 6'd19,
    PH_RD_ACK_BIT  = 6'd20,
    PH_RD_ACK_HI   = 6'd21,
    PH_RD_ACK_LO   = 6'd22
  } phase_t;

  typedef enum logic [1:0] {
    REG_PHASE_TICKS    = 2'd0,
    REG_ACK_TIMEOUT    = 2'd1,
    REG_DEVICE_ADDRESS = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] phase_ticks;
    logic [7:0]  ack_timeout;
    logic [6:0]  device_address;
  } cfg_t;

  // One classified tick as it travels from the front to the back.
  typedef struct packed {
    logic        start;
    cmd_t        cmd;
    phase_t      first_phase;
    logic        load;
    logic [7:0]  load_byte;
    logic        clear_nack;
    logic        sda;
  } tick_t;

endpackage

>>> rtl/core/i2cm_if.sv
`timescale 1ns / 1ps
// Valid/ready channels of the I2C master bit engine: tick input, result output
// and configuration writes. Depends on nothing.
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] data_byte;
  logic       sda_in;
  modport source (output valid, command, data_byte, sda_in, input ready);
  modport sink   (input valid, command, data_byte, sda_in, output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda_drive;
  logic       sda_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       ack_missing;
  modport source (output valid, scl, sda_drive, sda_level, busy_res, done_res,
                  read_data, ack_missing, input ready);
  modport sink   (input valid, scl, sda_drive, sda_level, busy_res, done_res,
                  read_data, ack_missing, output ready);
endinterface

interface i2cm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [15:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

>>> rtl/core/i2cm_front.sv
`timescale 1ns / 1ps
// Front of the bit engine: accepts ticks and decodes the command into a
// tick_t entry for the queue. Depends on i2cm_pkg and i2cm_if.
module i2cm_front (
  i2cm_in_if.sink            item,
  input  logic [6:0]         device_address,
  input  logic               push_ready,
  output logic               push,
  output i2cm_pkg::tick_t    push_data
);

  i2cm_pkg::cmd_t cmd;

  assign cmd        = i2cm_pkg::cmd_t'(item.command);
  assign item.ready = push_ready;
  assign push       = item.valid && push_ready;

  always_comb begin
    push_data             = '0;
    push_data.cmd         = cmd;
    push_data.sda         = item.sda_in;
    push_data.start       = 1'b1;
    push_data.first_phase = i2cm_pkg::PH_IDLE;
    unique case (cmd)
      i2cm_pkg::CMD_NONE: begin
        push_data.start = 1'b0;
      end
      i2cm_pkg::CMD_START: begin
        push_data.first_phase = i2cm_pkg::PH_ST_SDA_HI;
      end
      i2cm_pkg::CMD_STOP: begin
        push_data.first_phase = i2cm_pkg::PH_SP_SCL_LO;
      end
      i2cm_pkg::CMD_WRITE: begin
        push_data.first_phase = i2cm_pkg::PH_WR_PREP;
        push_data.load        = 1'b1;
        push_data.load_byte   = item.data_byte;
        push_data.clear_nack  = 1'b1;
      end
      i2cm_pkg::CMD_ADDR_WR, i2cm_pkg::CMD_ADDR_RD: begin
        push_data.first_phase = i2cm_pkg::PH_WR_PREP;
        push_data.load        = 1'b1;
        push_data.load_byte   = {device_address, cmd == i2cm_pkg::CMD_ADDR_RD};
        push_data.clear_nack  = 1'b1;
      end
      default: begin
        // read with ACK or NACK: shift register starts empty
        push_data.first_phase = i2cm_pkg::PH_RD_RELEASE;
        push_data.load        = 1'b1;
        push_data.load_byte   = 8'd0;
      end
    endcase
  end

endmodule

>>> rtl/core/i2cm_queue.sv
`timescale 1ns / 1ps
// Short FIFO of decoded ticks between front and back.
// Depends on i2cm_pkg for the entry type.
module i2cm_queue #(
  parameter int unsigned DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  i2cm_pkg::tick_t              push_data,
  output logic                         push_ready,
  input  logic                         pop,
  output logic                         pop_valid,
  output i2cm_pkg::tick_t              pop_data,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH+1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  i2cm_pkg::tick_t   entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

>>> rtl/core/i2cm_back.sv
`timescale 1ns / 1ps
// Back of the bit engine: bus phase sequencer, one tick per step, and the
// result register. Depends on i2cm_pkg and i2cm_if.
module i2cm_back #(
  parameter int unsigned PHASE_TIMER_BITS = i2cm_pkg::PHASE_TIMER_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  i2cm_pkg::cfg_t     cfg,
  input  logic               tick_valid,
  input  i2cm_pkg::tick_t    tick,
  output logic               tick_pop,
  i2cm_out_if.source         result
);

  localparam int unsigned B = PHASE_TIMER_BITS;
  localparam int unsigned W = (B > i2cm_pkg::PHASE_TICKS_BITS) ? B : i2cm_pkg::PHASE_TICKS_BITS;
  localparam logic [W-1:0] TMAX = W'({B{1'b1}});

  i2cm_pkg::phase_t step, step_next, nx, enter_ph;
  i2cm_pkg::cmd_t   op, op_next;
  logic [B-1:0] timer, timer_next, tdec, load_val;
  logic [W-1:0] p_ext;
  logic [7:0]   shift, shift_next, rx, rx_next, retry, retry_next;
  logic [3:0]   bidx, bidx_next;
  logic         scl_r, scl_next, drv, drv_next, lvl, lvl_next, nack, nack_next;
  logic         done_next, enter_en;

  assign tick_pop = tick_valid && (!result.valid || result.ready);

  // Phase length: zero counts as one, long values clip to the timer range.
  assign p_ext    = W'(cfg.phase_ticks);
  assign load_val = (p_ext == '0) ? B'(1) : ((p_ext > TMAX) ? B'(TMAX) : B'(p_ext));

  always_ff @(posedge clk) begin
    if (rst) begin
      step  <= i2cm_pkg::PH_IDLE;
      timer <= '0;
      op    <= i2cm_pkg::CMD_NONE;
      shift <= '0;
      bidx  <= '0;
      retry <= '0;
      scl_r <= 1'b1;
      drv   <= 1'b1;
      lvl   <= 1'b1;
      rx    <= '0;
      nack  <= 1'b0;
    end else if (tick_pop) begin
      step  <= step_next;
      timer <= timer_next;
      op    <= op_next;
      shift <= shift_next;
      bidx  <= bidx_next;
      retry <= retry_next;
      scl_r <= scl_next;
      drv   <= drv_next;
      lvl   <= lvl_next;
      rx    <= rx_next;
      nack  <= nack_next;
    end
  end

  always_comb begin
    step_next  = step;
    timer_next = timer;
    op_next    = op;
    shift_next = shift;
    bidx_next  = bidx;
    retry_next = retry;
    scl_next   = scl_r;
    drv_next   = drv;
    lvl_next   = lvl;
    rx_next    = rx;
    nack_next  = nack;
    done_next  = 1'b0;
    enter_en   = 1'b0;
    enter_ph   = i2cm_pkg::PH_IDLE;
    nx         = i2cm_pkg::PH_IDLE;
    tdec       = (timer != '0) ? timer - B'(1) : '0;

    if (step == i2cm_pkg::PH_IDLE) begin
      if (tick.start) begin
        op_next    = tick.cmd;
        bidx_next  = '0;
        retry_next = '0;
        if (tick.load) begin
          shift_next = tick.load_byte;
        end
        if (tick.clear_nack) begin
          nack_next = 1'b0;
        end
        enter_en = 1'b1;
        enter_ph = tick.first_phase;
      end
    end else begin
      timer_next = tdec;
      if (tdec == '0) begin
        unique case (step)
          i2cm_pkg::PH_ST_SDA_HI:  nx = i2cm_pkg::PH_ST_SCL_HI;
          i2cm_pkg::PH_ST_SCL_HI:  nx = i2cm_pkg::PH_ST_SDA_LO;
          i2cm_pkg::PH_ST_SDA_LO:  nx = i2cm_pkg::PH_ST_SCL_LO;
          i2cm_pkg::PH_SP_SCL_LO:  nx = i2cm_pkg::PH_SP_SDA_LO;
          i2cm_pkg::PH_SP_SDA_LO:  nx = i2cm_pkg::PH_SP_SCL_HI;
          i2cm_pkg::PH_SP_SCL_HI:  nx = i2cm_pkg::PH_SP_SDA_HI;
          i2cm_pkg::PH_WR_PREP:    nx = i2cm_pkg::PH_WR_BIT;
          i2cm_pkg::PH_WR_BIT: begin
            shift_next = {shift[6:0], 1'b0};
            nx         = i2cm_pkg::PH_WR_SCL_HI;
          end
          i2cm_pkg::PH_WR_SCL_HI:  nx = i2cm_pkg::PH_WR_SCL_LO;
          i2cm_pkg::PH_WR_SCL_LO: begin
            bidx_next = bidx + 4'd1;
            nx = (bidx_next < i2cm_pkg::BITS_PER_BYTE) ? i2cm_pkg::PH_WR_BIT
                                                       : i2cm_pkg::PH_WR_ACK_POLL;
          end
          i2cm_pkg::PH_WR_ACK_POLL: begin
            if (!tick.sda) begin
              nx = i2cm_pkg::PH_WR_ACK_END;
            end else if (retry >= cfg.ack_timeout) begin
              nack_next = 1'b1;
              nx        = i2cm_pkg::PH_SP_SCL_LO;
            end else begin
              retry_next = retry + 8'd1;
              nx         = i2cm_pkg::PH_WR_ACK_POLL;
            end
          end
          i2cm_pkg::PH_RD_RELEASE: nx = i2cm_pkg::PH_RD_SCL_LO;
          i2cm_pkg::PH_RD_SCL_LO:  nx = i2cm_pkg::PH_RD_SCL_HI;
          i2cm_pkg::PH_RD_SCL_HI: begin
            shift_next = {shift[6:0], tick.sda};
            nx         = i2cm_pkg::PH_RD_NEXT;
          end
          i2cm_pkg::PH_RD_NEXT: begin
            bidx_next = bidx + 4'd1;
            if (bidx_next < i2cm_pkg::BITS_PER_BYTE) begin
              nx = i2cm_pkg::PH_RD_SCL_LO;
            end else begin
              rx_next = shift;
              nx      = i2cm_pkg::PH_RD_PREP;
            end
          end
          i2cm_pkg::PH_RD_PREP:    nx = i2cm_pkg::PH_RD_ACK_BIT;
          i2cm_pkg::PH_RD_ACK_BIT: nx = i2cm_pkg::PH_RD_ACK_HI;
          i2cm_pkg::PH_RD_ACK_HI:  nx = i2cm_pkg::PH_RD_ACK_LO;
          default:                 nx = i2cm_pkg::PH_IDLE;
        endcase
        if (nx == i2cm_pkg::PH_IDLE) begin
          step_next = i2cm_pkg::PH_IDLE;
          done_next = 1'b1;
        end else begin
          enter_en = 1'b1;
          enter_ph = nx;
        end
      end
    end

    // Entering a phase sets its pins and restarts the phase timer.
    if (enter_en) begin
      step_next  = enter_ph;
      timer_next = load_val;
      unique case (enter_ph) inside
        i2cm_pkg::PH_ST_SDA_HI, i2cm_pkg::PH_SP_SDA_HI: begin
          drv_next = 1'b1;
          lvl_next = 1'b1;
        end
        i2cm_pkg::PH_ST_SDA_LO, i2cm_pkg::PH_SP_SDA_LO: begin
          drv_next = 1'b1;
          lvl_next = 1'b0;
        end
        i2cm_pkg::PH_ST_SCL_HI, i2cm_pkg::PH_SP_SCL_HI, i2cm_pkg::PH_WR_SCL_HI,
        i2cm_pkg::PH_RD_SCL_HI, i2cm_pkg::PH_RD_ACK_HI: begin
          scl_next = 1'b1;
        end
        i2cm_pkg::PH_ST_SCL_LO, i2cm_pkg::PH_SP_SCL_LO, i2cm_pkg::PH_WR_SCL_LO,
        i2cm_pkg::PH_WR_ACK_END, i2cm_pkg::PH_RD_SCL_LO, i2cm_pkg::PH_RD_ACK_LO: begin
          scl_next = 1'b0;
        end
        i2cm_pkg::PH_WR_PREP, i2cm_pkg::PH_RD_PREP: begin
          scl_next = 1'b0;
          drv_next = 1'b1;
        end
        i2cm_pkg::PH_WR_BIT: begin
          drv_next = 1'b1;
          lvl_next = shift_next[7];
        end
        i2cm_pkg::PH_WR_ACK_POLL: begin
          drv_next = 1'b0;
          lvl_next = 1'b1;
          scl_next = 1'b1;
        end
        i2cm_pkg::PH_RD_RELEASE: begin
          drv_next = 1'b0;
          lvl_next = 1'b1;
        end
        i2cm_pkg::PH_RD_ACK_BIT: begin
          drv_next = 1'b1;
          lvl_next = op_next == i2cm_pkg::CMD_READ_NACK;
        end
        default: begin
        end
      endcase
    end
  end

  // Result register: load on every executed tick, hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (tick_pop) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_pop) begin
      result.scl         <= scl_next;
      result.sda_drive   <= drv_next;
      result.sda_level   <= drv_next && lvl_next;
      result.busy_res    <= step_next != i2cm_pkg::PH_IDLE;
      result.done_res    <= done_next;
      result.read_data   <= rx_next;
      result.ack_missing <= nack_next;
    end
  end

endmodule

>>> rtl/core/i2c_master_bit_engine.sv
`timescale 1ns / 1ps
// Top level of the I2C master bit engine (seven-bit addressing).
// Depends on i2cm_pkg, i2cm_if, i2cm_front, i2cm_queue and i2cm_back.
//
// Each beat on the item channel is one bus timing tick: it carries a command,
// a byte to send and the sampled SDA level, and it yields exactly one beat on
// the result channel with the SCL/SDA drive state, busy, a done pulse, the last
// received byte and the ACK-missing flag. Commands (start, stop, write byte,
// address for write or read, read with ACK or NACK) are taken only on a tick
// that finds the engine idle, and are ignored otherwise. Every bus phase lasts
// phase_ticks ticks (zero counts as one); a write polls ACK once per phase and
// after ack_timeout plus one failed polls runs the stop sequence and raises
// ack_missing. The engine sustains one tick per clock while the result channel
// keeps up: the front decodes a beat into a four-entry queue and the back phase
// sequencer retires one queue entry per cycle, when its result slot is free,
// into its result register. An accepted item beat passes through the queue
// register and then the result register before its result beat is offered.
// Back-pressure on the result channel fills the queue, and the item channel
// stalls only once the queue is full. Configuration writes are always taken
// and belong in idle periods with no beats in flight.
module i2c_master_bit_engine #(
  parameter int unsigned PHASE_TIMER_BITS = i2cm_pkg::PHASE_TIMER_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH      = i2cm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  i2cm_cfg_if.sink    cfg,
  i2cm_in_if.sink     item,
  i2cm_out_if.source  result
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  i2cm_pkg::cfg_t   cfg_reg;
  i2cm_pkg::tick_t  push_data;
  i2cm_pkg::tick_t  pop_data;
  logic             push;
  logic             push_ready;
  logic             pop;
  logic             pop_valid;
  logic [CNT_W-1:0] q_count;

  // Configuration registers: always ready, unknown indexes drop the beat.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.phase_ticks    <= i2cm_pkg::PHASE_TICKS_RST;
      cfg_reg.ack_timeout    <= i2cm_pkg::ACK_TIMEOUT_RST;
      cfg_reg.device_address <= i2cm_pkg::DEV_ADDR_RST;
    end else if (cfg.valid) begin
      case (i2cm_pkg::cfg_reg_t'(cfg.reg_index))
        i2cm_pkg::REG_PHASE_TICKS:    cfg_reg.phase_ticks    <= cfg.wdata;
        i2cm_pkg::REG_ACK_TIMEOUT:    cfg_reg.ack_timeout    <= cfg.wdata[7:0];
        i2cm_pkg::REG_DEVICE_ADDRESS: cfg_reg.device_address <= cfg.wdata[6:0];
        default: begin
        end
      endcase
    end
  end

  // Front: accept and classify ticks.
  i2cm_front u_front (
    .item           (item),
    .device_address (cfg_reg.device_address),
    .push_ready     (push_ready),
    .push           (push),
    .push_data      (push_data)
  );

  // Decoupling queue between the decoder and the sequencer.
  i2cm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .count      (q_count)
  );

  // Back: phase sequencer and result register.
  i2cm_back #(
    .PHASE_TIMER_BITS (PHASE_TIMER_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_reg),
    .tick_valid (pop_valid),
    .tick       (pop_data),
    .tick_pop   (pop),
    .result     (result)
  );

  // A sequence that just finished cannot still report busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.done_res |-> !result.busy_res)
    else $error("done pulse while busy");

  // A released SDA line always reports sda_level low.
  a_release_level: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.sda_drive |-> !result.sda_level)
    else $error("sda level shown while released");

  // The front only takes a beat when the queue has room.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |-> q_count < CNT_W'(QUEUE_DEPTH))
    else $error("beat accepted into full queue");

  // Queue entries drain into the sequencer whenever the result slot is free.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    pop_valid && !result.valid |-> pop)
    else $error("queue stalled with free result slot");

endmodule
